@@ rtl/core/uart_fifo_register_model_defines.svh @@
// Assertion helpers for the RTL file that carries checks.
// All checks sample on clk_i and are disabled while rst_ni is low.
`ifndef UART_FIFO_REGISTER_MODEL_DEFINES_SVH
`define UART_FIFO_REGISTER_MODEL_DEFINES_SVH

// Same-cycle implication.
`define UFRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UFRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ufrm_pkg.sv @@
package ufrm_pkg;

  localparam int WordW  = 32;
  localparam int ByteW  = 8;
  localparam int LimitW = 5;
  localparam int ApbAddrW = 2;

  // Most results one drain transaction can give.
  localparam logic [LimitW-1:0] MaxResults = 5'd16;

  // Status bit positions.
  localparam int StatTxe  = 0;
  localparam int StatRxne = 1;

  // Configuration register byte address.
  localparam logic [ApbAddrW-1:0] RegAddrRxFaultMask = 2'd0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RECV  = 2'd2,
    OP_DRAIN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEL_TX     = 2'd0,
    SEL_RX     = 2'd1,
    SEL_STATUS = 2'd2,
    SEL_IEN    = 2'd3
  } sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // run the accepted transaction and load its first result
    logic step;  // pop one more transmit byte of a drain
    logic last;  // that step gives the final result
  } ufrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] extra;  // results beyond the first for the offered transaction
  } ufrm_sts_t;

endpackage

@@ rtl/core/ufrm_if.sv @@
// Request channel: one bus access, received byte or drain per transaction.
interface ufrm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  reg_select;
  logic [31:0] write_data;
  logic [7:0]  rx_byte;
  logic [4:0]  drain_limit;

  modport source (output valid, opcode, reg_select, write_data, rx_byte, drain_limit,
                  input ready);
  modport sink   (input valid, opcode, reg_select, write_data, rx_byte, drain_limit,
                  output ready);
endinterface

// Response channel: one result per transaction; a drain of several bytes gives one per byte.
interface ufrm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [7:0]  tx_byte;
  logic        tx_valid;
  logic        last;
  logic        irq_pulse;
  logic        tx_space;
  logic        rx_ready;

  modport source (output valid, read_data, tx_byte, tx_valid, last, irq_pulse, tx_space,
                  rx_ready, input ready);
  modport sink   (input valid, read_data, tx_byte, tx_valid, last, irq_pulse, tx_space,
                  rx_ready, output ready);
endinterface

@@ rtl/core/ufrm_fifo.sv @@
module ufrm_fifo import ufrm_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] push_data_i,
  input  logic             pop_i,
  output logic [ByteW-1:0] head_o
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic [ByteW-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ByteW-1:0] head_q;

  // Ring pointers wrap at the last entry.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Storage with a registered read of the next head entry; a write to that
  // entry in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (push_i && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= push_data_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  assign head_o = head_q;

endmodule

@@ rtl/core/ufrm_datapath.sv @@
module ufrm_datapath import ufrm_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufrm_cmd_t         cmd_i,
  output ufrm_sts_t         sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [1:0]        reg_select_i,
  input  logic [WordW-1:0]  write_data_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic [LimitW-1:0] drain_limit_i,
  input  logic [ByteW-1:0]  rx_fault_mask_i,
  output logic [WordW-1:0]  read_data_o,
  output logic [ByteW-1:0]  tx_byte_o,
  output logic              tx_valid_o,
  output logic              last_o,
  output logic              irq_pulse_o,
  output logic              tx_space_o,
  output logic              rx_ready_o
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > LimitW) ? FW : LimitW;
  localparam logic [FW-1:0] FullCount = FW'(DEPTH);

  op_e  op;
  sel_e sel;

  logic [FW-1:0]    tx_fill_q, tx_fill_d;
  logic [FW-1:0]    rx_fill_q, rx_fill_d;
  logic [WordW-1:0] ien_q;
  logic [WordW-1:0] tx_word_q;
  logic [ByteW-1:0] tx_head, rx_head;

  logic             tx_full, rx_full, txe_cur, rxne_cur;
  logic             tx_push, tx_pop, rx_push, rx_pop;
  logic             is_drain, irq_src;
  logic [LimitW-1:0] limit_sat;
  logic [CW-1:0]    lim_ext, fill_ext, drain_n;
  logic [1:0]       st_new;
  logic [WordW-1:0] rd_word;

  logic [WordW-1:0] read_data_q;
  logic [ByteW-1:0] tx_byte_q;
  logic             tx_valid_q, last_q, irq_q, tx_space_q, rx_ready_q;

  assign op  = op_e'(opcode_i);
  assign sel = sel_e'(reg_select_i);

  // Current FIFO status.
  assign tx_full  = (tx_fill_q == FullCount);
  assign rx_full  = (rx_fill_q == FullCount);
  assign txe_cur  = !tx_full;
  assign rxne_cur = (rx_fill_q != '0);

  // Drain length: the saturated limit or the transmit fill, whichever is less.
  assign limit_sat = (drain_limit_i > MaxResults) ? MaxResults : drain_limit_i;
  assign lim_ext   = CW'(limit_sat);
  assign fill_ext  = CW'(tx_fill_q);
  assign drain_n   = (lim_ext < fill_ext) ? lim_ext : fill_ext;
  assign is_drain  = (op == OP_DRAIN);

  assign sts_o.extra = (is_drain && (drain_n > CW'(1))) ? 4'(drain_n - CW'(1)) : 4'd0;

  // FIFO strobes.
  assign tx_push = cmd_i.exec && (op == OP_WRITE) && (sel == SEL_TX) && !tx_full;
  assign rx_push = cmd_i.exec && (op == OP_RECV) && !rx_full;
  assign rx_pop  = cmd_i.exec && (op == OP_READ) && (sel == SEL_RX) && rxne_cur;
  assign tx_pop  = (cmd_i.exec && is_drain && (drain_n != '0)) || cmd_i.step;

  // Fill counts; a drain settles its whole count when it starts.
  always_comb begin
    tx_fill_d = tx_fill_q;
    rx_fill_d = rx_fill_q;
    if (tx_push) begin
      tx_fill_d = tx_fill_q + 1'b1;
    end else if (cmd_i.exec && is_drain) begin
      tx_fill_d = tx_fill_q - FW'(drain_n);
    end
    if (rx_push) begin
      rx_fill_d = rx_fill_q + 1'b1;
    end else if (rx_pop) begin
      rx_fill_d = rx_fill_q - 1'b1;
    end
  end

  // Status after the whole transaction and the interrupt check.
  always_comb begin
    st_new           = '0;
    st_new[StatTxe]  = (tx_fill_d != FullCount);
    st_new[StatRxne] = (rx_fill_d != '0);
  end

  assign irq_src = ((op == OP_WRITE) && (sel == SEL_TX)) || ((op == OP_RECV) && !rx_full);

  // Bus read mux.
  always_comb begin
    rd_word = '0;
    if (op == OP_READ) begin
      case (sel)
        SEL_TX:     rd_word = tx_word_q;
        SEL_RX:     rd_word = rxne_cur ? WordW'(rx_head) : '0;
        SEL_STATUS: rd_word = WordW'({rxne_cur, txe_cur});
        SEL_IEN:    rd_word = ien_q;
        default:    rd_word = '0;
      endcase
    end
  end

  // Control-side state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_fill_q <= '0;
      rx_fill_q <= '0;
      ien_q     <= '0;
      tx_word_q <= '0;
    end else begin
      tx_fill_q <= tx_fill_d;
      rx_fill_q <= rx_fill_d;
      if (cmd_i.exec && (op == OP_WRITE) && (sel == SEL_IEN)) begin
        ien_q <= write_data_i;
      end
      if (cmd_i.exec && (op == OP_WRITE) && (sel == SEL_TX)) begin
        tx_word_q <= write_data_i;
      end
    end
  end

  ufrm_fifo #(.DEPTH(DEPTH)) u_tx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tx_push),
    .push_data_i (write_data_i[ByteW-1:0]),
    .pop_i       (tx_pop),
    .head_o      (tx_head)
  );

  ufrm_fifo #(.DEPTH(DEPTH)) u_rx_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rx_push),
    .push_data_i (rx_byte_i ^ rx_fault_mask_i),
    .pop_i       (rx_pop),
    .head_o      (rx_head)
  );

  // Result register; status bits stay from the start of a drain.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      read_data_q <= rd_word;
      tx_valid_q  <= is_drain && (drain_n != '0);
      tx_byte_q   <= (is_drain && (drain_n != '0)) ? tx_head : '0;
      last_q      <= !(is_drain && (drain_n > CW'(1)));
      irq_q       <= irq_src && ((ien_q[1:0] & st_new) != 2'b00);
      tx_space_q  <= st_new[StatTxe];
      rx_ready_q  <= st_new[StatRxne];
    end else if (cmd_i.step) begin
      read_data_q <= '0;
      tx_valid_q  <= 1'b1;
      tx_byte_q   <= tx_head;
      last_q      <= cmd_i.last;
      irq_q       <= 1'b0;
    end
  end

  assign read_data_o = read_data_q;
  assign tx_byte_o   = tx_byte_q;
  assign tx_valid_o  = tx_valid_q;
  assign last_o      = last_q;
  assign irq_pulse_o = irq_q;
  assign tx_space_o  = tx_space_q;
  assign rx_ready_o  = rx_ready_q;

endmodule

@@ rtl/core/ufrm_ctrl.sv @@
`include "uart_fifo_register_model_defines.svh"

module ufrm_ctrl import ufrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ufrm_cmd_t cmd_o,
  input  ufrm_sts_t sts_i
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e     state_q;
  logic [3:0] remain_q;
  logic       out_valid_q;
  logic       slot_free;

  // The result register can take a new result when empty or being read.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;

  assign cmd_o.exec = in_valid_i && in_ready_o;
  assign cmd_o.step = (state_q == ST_DRAIN) && slot_free;
  assign cmd_o.last = (remain_q == 4'd1);

  assign out_valid_o = out_valid_q;

  // State, remaining drain results and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.exec || cmd_o.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.exec && (sts_i.extra != '0)) begin
            remain_q <= sts_i.extra;
            state_q  <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cmd_o.step) begin
            remain_q <= remain_q - 1'b1;
            if (remain_q == 4'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `UFRM_ASSERT_NOW(a_drain_has_work, state_q == ST_DRAIN, remain_q != '0, "drain state with no results left")
  `UFRM_ASSERT_NEXT(a_multi_enters_drain, cmd_o.exec && (sts_i.extra != '0), (state_q == ST_DRAIN) && out_valid_q, "multi-result drain did not start")
  `UFRM_ASSERT_NEXT(a_last_step_exits, cmd_o.step && cmd_o.last, state_q == ST_IDLE, "drain did not end after its last result")

endmodule

@@ rtl/core/uart_fifo_register_model.sv @@
// Each transaction gives its first result in the output register in the cycle after acceptance.
// A drain of n bytes gives n results, one per cycle while rsp_o.ready lets the result register
// take them, and blocks new transactions until its last result has been loaded.
// FIFO heads are read from registered memory ports, so one pop per cycle is sustained.
// Reset (rst_ni low, asynchronous) clears pointers, fill counts, IEN, the TX word and the
// fault mask; FIFO storage holds no reset value and needs no clearing pass.
module uart_fifo_register_model import ufrm_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ufrm_req_if.sink            req_i,
  ufrm_rsp_if.source          rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  output logic                pready
);

  logic [ByteW-1:0] rx_fault_mask_q;
  ufrm_cmd_t        cmd;
  ufrm_sts_t        sts;

  // Configuration register, written in the APB access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_fault_mask_q <= '0;
    end else if (psel && penable && pwrite) begin
      rx_fault_mask_q <= pwdata[ByteW-1:0];
    end
  end

  assign prdata = (paddr == RegAddrRxFaultMask) ? WordW'(rx_fault_mask_q) : '0;

  ufrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ufrm_datapath #(.DEPTH(FIFO_DEPTH)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (req_i.opcode),
    .reg_select_i    (req_i.reg_select),
    .write_data_i    (req_i.write_data),
    .rx_byte_i       (req_i.rx_byte),
    .drain_limit_i   (req_i.drain_limit),
    .rx_fault_mask_i (rx_fault_mask_q),
    .read_data_o     (rsp_o.read_data),
    .tx_byte_o       (rsp_o.tx_byte),
    .tx_valid_o      (rsp_o.tx_valid),
    .last_o          (rsp_o.last),
    .irq_pulse_o     (rsp_o.irq_pulse),
    .tx_space_o      (rsp_o.tx_space),
    .rx_ready_o      (rsp_o.rx_ready)
  );

endmodule
